[sv/dbrseq_pkg.sv]
// ----------------------------------------------------------------------------
// dbrseq_pkg
// Shared types and constants of the debounced two-button run sequencer.
// ----------------------------------------------------------------------------
package dbrseq_pkg;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsCfgW  = 16;
  localparam int unsigned StateW  = 3;
  localparam int unsigned ModeW   = 2;

  // Stream payload widths (fields packed, padded to whole bytes)
  localparam int unsigned InFieldsW  = TimeW + 4;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 3 + StateW + 3 + ModeW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_MS    = 2'd0,
    CFG_START_DELAY_MS = 2'd1,
    CFG_ACTIVE_LOW     = 2'd2,
    CFG_SENSOR_PRESENT = 2'd3
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [MsCfgW-1:0] DebounceMsRst   = 16'd20;
  localparam logic [MsCfgW-1:0] StartDelayMsRst = 16'd1000;

  // Solver mode change requests
  typedef enum logic [ModeW-1:0] {
    MODE_NONE   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_ZOOM   = 2'd2
  } mode_req_t;

  // Debounce settings shared by both button filters
  typedef struct packed {
    logic [MsCfgW-1:0] debounce_ms;
    logic              active_low;
  } db_cfg_t;

endpackage

[sv/dbrseq_debounce.sv]
// ----------------------------------------------------------------------------
// dbrseq_debounce
// Timestamp debounce filter for one button with a latched press event.
// ----------------------------------------------------------------------------
module dbrseq_debounce import dbrseq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  db_cfg_t          cfg,
  input  logic             en,        // tick request advances this cycle
  input  logic             level,     // raw pin level
  input  logic [TimeW-1:0] now_ms,
  input  logic             consume,   // sequencer takes the pending press
  output logic             pending    // pending press after this tick's filter
);

  logic             seen_r;
  logic             stable_r;
  logic             pend_r;
  logic [TimeW-1:0] when_r;

  logic             raw;
  logic [TimeW-1:0] when_nxt;
  logic [TimeW-1:0] elapsed;
  logic             settle;
  logic             stable_nxt;
  logic             pend_upd;

  // Filter the raw level against the time of its last change
  always_comb begin
    raw        = level ^ cfg.active_low;
    when_nxt   = (raw != seen_r) ? now_ms : when_r;
    elapsed    = now_ms - when_nxt;
    settle     = (elapsed >= {{(TimeW-MsCfgW){1'b0}}, cfg.debounce_ms}) && (stable_r != raw);
    stable_nxt = settle ? raw : stable_r;
    pend_upd   = pend_r | (settle & raw);
  end

  assign pending = pend_upd;

  // Commit filter state on each tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      stable_r <= 1'b0;
      pend_r   <= 1'b0;
      when_r   <= '0;
    end else if (en) begin
      seen_r   <= raw;
      stable_r <= stable_nxt;
      pend_r   <= pend_upd & ~consume;
      when_r   <= when_nxt;
    end
  end

endmodule

[sv/debounced_two_button_run_sequencer_core.sv]
// ----------------------------------------------------------------------------
// debounced_two_button_run_sequencer_core
// Button debounce and six-state search/zoom run sequencer, one result per tick.
// ----------------------------------------------------------------------------
// Each tick request on the input stream gives exactly one result request on
// the output stream. A tick is taken into an input register, the debounce
// filters and the run sequencer settle it combinationally, and the result
// lands in an output register; a new tick can be accepted every cycle while
// the output side keeps up, so the throughput is one tick per cycle. The
// state update between the input and output registers (one 32-bit
// subtract-compare per button feeding the press decision, plus the
// start-delay compare) sets the cycle. Configuration writes take effect on
// the next cycle and should be made while no tick is in flight.
module debounced_two_button_run_sequencer_core import dbrseq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [MsCfgW-1:0]   cfg_wdata,
  // Tick input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // in_tdata: now_ms[31:0], search_level, zoom_level, sensor_done,
  //           maze_searched, zero pad
  input  logic [InDataW-1:0]  in_tdata,
  // Result output stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // out_tdata: led_search, led_zoom, led_ready, run_state[2:0],
  //            sensor_update_req, sensor_consume_req, solver_step_req,
  //            mode_set_req[1:0], zero pad
  output logic [OutDataW-1:0] out_tdata
);

  typedef enum logic [StateW-1:0] {
    PH_WAIT_SEARCH  = 3'd0,
    PH_SEARCH_DELAY = 3'd1,
    PH_SEARCHING    = 3'd2,
    PH_WAIT_ZOOM    = 3'd3,
    PH_ZOOM_DELAY   = 3'd4,
    PH_ZOOMING      = 3'd5
  } phase_t;

  // Configuration registers
  logic [MsCfgW-1:0] debounce_ms_r;
  logic [MsCfgW-1:0] start_delay_ms_r;
  logic              active_low_r;
  logic              sensor_present_r;
  db_cfg_t           db_cfg;

  // Input stage and output stage
  logic                 s1_valid_r;
  logic [InFieldsW-1:0] s1_data_r;
  logic                 out_valid_r;
  logic [OutFieldsW-1:0] out_data_r;
  logic                 advance;

  // Sequencer state
  phase_t           phase_r, phase_nxt;
  logic [TimeW-1:0] start_r, start_nxt;

  // Tick fields
  logic [TimeW-1:0] now_ms;
  logic             search_level, zoom_level, sensor_done, maze_searched;

  logic             search_pend, zoom_pend;
  logic             search_consume, zoom_consume;
  logic             active, stepped, delay_done;
  logic             upd, cons, step;
  mode_req_t        mode;
  logic             led_search, led_zoom, led_ready;
  logic [TimeW-1:0] phase_elapsed;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r    <= DebounceMsRst;
      start_delay_ms_r <= StartDelayMsRst;
      active_low_r     <= 1'b1;
      sensor_present_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEBOUNCE_MS:    debounce_ms_r    <= cfg_wdata;
        CFG_START_DELAY_MS: start_delay_ms_r <= cfg_wdata;
        CFG_ACTIVE_LOW:     active_low_r     <= cfg_wdata[0];
        CFG_SENSOR_PRESENT: sensor_present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign db_cfg = '{debounce_ms: debounce_ms_r, active_low: active_low_r};

  // Handshake: the input stage moves on when the output register is free
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-OutFieldsW){1'b0}}, out_data_r};

  // Unpack the held tick
  assign now_ms        = s1_data_r[TimeW-1:0];
  assign search_level  = s1_data_r[TimeW];
  assign zoom_level    = s1_data_r[TimeW+1];
  assign sensor_done   = s1_data_r[TimeW+2];
  assign maze_searched = s1_data_r[TimeW+3];

  // Button filters
  dbrseq_debounce u_search_db (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (db_cfg),
    .en      (advance),
    .level   (search_level),
    .now_ms  (now_ms),
    .consume (search_consume),
    .pending (search_pend)
  );

  dbrseq_debounce u_zoom_db (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (db_cfg),
    .en      (advance),
    .level   (zoom_level),
    .now_ms  (now_ms),
    .consume (zoom_consume),
    .pending (zoom_pend)
  );

  // Sensor and solver pulses in the active states
  always_comb begin
    active  = (phase_r == PH_SEARCHING) || (phase_r == PH_ZOOMING);
    upd     = active && sensor_present_r;
    stepped = active && (!sensor_present_r || sensor_done);
    cons    = active && sensor_present_r && sensor_done;
    step    = stepped;
  end

  // Advance the run sequencer
  always_comb begin
    phase_nxt      = phase_r;
    start_nxt      = start_r;
    mode           = MODE_NONE;
    search_consume = 1'b0;
    zoom_consume   = 1'b0;
    phase_elapsed  = now_ms - start_r;
    delay_done     = phase_elapsed >= {{(TimeW-MsCfgW){1'b0}}, start_delay_ms_r};
    unique case (phase_r)
      PH_WAIT_SEARCH: begin
        if (search_pend) begin
          search_consume = 1'b1;
          phase_nxt      = PH_SEARCH_DELAY;
          start_nxt      = now_ms;
        end
      end
      PH_SEARCH_DELAY: begin
        if (delay_done) begin
          mode      = MODE_SEARCH;
          phase_nxt = PH_SEARCHING;
        end
      end
      PH_SEARCHING: begin
        if (stepped && maze_searched) begin
          phase_nxt = PH_WAIT_ZOOM;
        end
      end
      PH_WAIT_ZOOM: begin
        if (zoom_pend) begin
          zoom_consume = 1'b1;
          phase_nxt    = PH_ZOOM_DELAY;
          start_nxt    = now_ms;
        end
      end
      PH_ZOOM_DELAY: begin
        if (delay_done) begin
          mode      = MODE_ZOOM;
          phase_nxt = PH_ZOOMING;
        end
      end
      PH_ZOOMING: ;
      default: phase_nxt = PH_WAIT_SEARCH;
    endcase
    led_search = (phase_nxt == PH_WAIT_SEARCH) || (phase_nxt == PH_SEARCH_DELAY) ||
                 (phase_nxt == PH_SEARCHING);
    led_zoom   = (phase_nxt == PH_ZOOM_DELAY) || (phase_nxt == PH_ZOOMING);
    led_ready  = (phase_nxt == PH_WAIT_ZOOM);
  end

  // Hold stages, state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_data_r   <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      phase_r     <= PH_WAIT_SEARCH;
      start_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_data_r <= in_tdata[InFieldsW-1:0];
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        phase_r     <= phase_nxt;
        start_r     <= start_nxt;
        out_valid_r <= 1'b1;
        out_data_r  <= {mode, step, cons, upd, phase_nxt, led_ready, led_zoom, led_search};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
